// ===== rtl/lph_pkg.sv =====
package lph_pkg;

    localparam int KEY_W       = 31;
    localparam int OPC_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int BUCKET_W    = 4;
    localparam int BUCKETS_DEF = 16;
    localparam int Q_DEPTH     = 2;

    localparam logic [OPC_W-1:0] OPC_INSERT = 2'd0;
    localparam logic [OPC_W-1:0] OPC_SEARCH = 2'd1;
    localparam logic [OPC_W-1:0] OPC_DELETE = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_SEARCH,
        OP_DELETE,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_GONE  = 2'd2
    } t_mark;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        t_mark            mark;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_REM,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_FIN
    } t_bstate;

endpackage

// ===== rtl/lph_front.sv =====
module lph_front import lph_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [OPC_W-1:0]           i_opcode,
    input  logic [KEY_W-1:0]           i_key,
    input  logic                       i_full,
    output logic                       o_busy,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    output logic [$clog2(BUCKETS)-1:0] o_home
);

    localparam int BW = $clog2(BUCKETS);
    localparam int SH = KEY_W + BW;
    localparam int QW = KEY_W + 32 - SH;
    localparam logic [31:0] RECIP =
        32'(((64'd1 << SH) + 64'(BUCKETS - 1)) / 64'(BUCKETS));
    localparam logic [BW:0] MOD = (BW + 1)'(BUCKETS);

    t_fstate             r_state, n_state;
    t_op                 r_op;
    logic [KEY_W-1:0]    r_key;
    logic [QW-1:0]       r_quo;
    logic [BW-1:0]       r_rem, n_rem;
    logic [KEY_W+31:0]   prod;
    logic [KEY_W-1:0]    qm;
    t_op                 dec_op;

    always_comb begin
        case (i_opcode)
            OPC_INSERT: dec_op = OP_INSERT;
            OPC_SEARCH: dec_op = OP_SEARCH;
            OPC_DELETE: dec_op = OP_DELETE;
            default:    dec_op = OP_NONE;
        endcase
    end

    // quotient by reciprocal multiply, exact for any 31-bit key
    always_comb begin
        prod  = (KEY_W + 32)'(r_key) * (KEY_W + 32)'(RECIP);
        qm    = KEY_W'(r_quo) * KEY_W'(MOD);
        n_rem = BW'(r_key - qm);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) n_state = F_MUL;
            end
            F_MUL: begin
                n_state = F_REM;
            end
            F_REM: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != F_IDLE);
        o_push = (r_state == F_PUSH) && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_op  <= dec_op;
            r_key <= i_key;
        end
        if (r_state == F_MUL) r_quo <= prod[KEY_W+31:SH];
        if (r_state == F_REM) r_rem <= n_rem;
    end

    assign o_cmd.op  = r_op;
    assign o_cmd.key = r_key;
    assign o_home    = r_rem;

endmodule

// ===== rtl/lph_fifo.sv =====
module lph_fifo import lph_pkg::*; #(
    parameter int DW    = 1,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [DW-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] CNT_FULL = (AW + 1)'(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/lph_back.sv =====
module lph_back import lph_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  t_cmd                       i_cmd,
    input  logic [$clog2(BUCKETS)-1:0] i_home,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [STATUS_W-1:0]        o_status,
    output logic [BUCKET_W-1:0]        o_bucket
);

    localparam int BW = $clog2(BUCKETS);
    localparam logic [BW-1:0] LAST = BW'(BUCKETS - 1);

    function automatic logic [BW-1:0] nxt(input logic [BW-1:0] b);
        nxt = (b == LAST) ? '0 : b + 1'b1;
    endfunction

    t_slot            r_slot [BUCKETS];
    t_slot            r_rd;

    t_bstate          r_state, n_state;
    logic [BW-1:0]    r_clr;
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [BW-1:0]    r_pend;
    logic [BW-1:0]    r_next;
    logic [BW-1:0]    r_cnt;
    logic             r_found;
    logic [BW-1:0]    r_hit;
    logic             r_free_ok;
    logic [BW-1:0]    r_free;

    logic             r_out_valid;
    t_status          r_status;
    logic [BUCKET_W-1:0] r_bucket;

    logic             hit;
    logic             stop;
    logic             out_free;
    logic             fin_go;
    logic             mem_we;
    logic [BW-1:0]    mem_wa;
    t_slot            mem_wd;
    logic [BW-1:0]    rd_addr;
    t_status          res_status;
    logic [BW-1:0]    res_bkt;
    logic [BW+BUCKET_W-1:0] bkt_ext;

    assign hit      = (r_rd.mark == MARK_USED) && (r_rd.key == r_key);
    assign stop     = hit || (r_rd.mark == MARK_EMPTY) || (r_cnt == LAST);
    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (r_clr == LAST) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (!i_empty) n_state = B_PROBE;
            end
            B_PROBE: begin
                if (stop) n_state = B_FIN;
            end
            B_FIN: begin
                if (out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == B_IDLE) && !i_empty;
        o_clearing = (r_state == B_CLEAR);
        fin_go     = (r_state == B_FIN) && out_free;
        rd_addr    = (r_state == B_IDLE) ? i_home : r_next;
        res_status = ST_NOTFOUND;
        res_bkt    = '0;
        mem_we     = 1'b0;
        mem_wa     = r_clr;
        mem_wd     = '{mark: MARK_EMPTY, key: '0};
        case (r_op)
            OP_INSERT: begin
                if (r_found) begin
                    res_status = ST_PRESENT;
                end else if (r_free_ok) begin
                    res_status = ST_DONE;
                    res_bkt    = r_free;
                    mem_wa     = r_free;
                    mem_wd     = '{mark: MARK_USED, key: r_key};
                    mem_we     = fin_go;
                end else begin
                    res_status = ST_FULL;
                end
            end
            OP_SEARCH: begin
                if (r_found) begin
                    res_status = ST_DONE;
                    res_bkt    = r_hit;
                end
            end
            OP_DELETE: begin
                if (r_found) begin
                    res_status = ST_DONE;
                    res_bkt    = r_hit;
                    mem_wa     = r_hit;
                    mem_wd     = '{mark: MARK_GONE, key: r_key};
                    mem_we     = fin_go;
                end
            end
            default: res_status = ST_NOTFOUND;
        endcase
        if (r_state == B_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '{mark: MARK_EMPTY, key: '0};
        end
    end

    assign bkt_ext = (BW + BUCKET_W)'(res_bkt);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_slot[mem_wa] <= mem_wd;
        r_rd <= r_slot[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr <= r_clr + 1'b1;
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op      <= i_cmd.op;
            r_key     <= i_cmd.key;
            r_pend    <= i_home;
            r_next    <= nxt(i_home);
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_state == B_PROBE) begin
            if (!r_free_ok && r_rd.mark != MARK_USED) begin
                r_free_ok <= 1'b1;
                r_free    <= r_pend;
            end
            if (hit) begin
                r_found <= 1'b1;
                r_hit   <= r_pend;
            end
            r_pend <= r_next;
            r_next <= nxt(r_next);
            r_cnt  <= r_cnt + 1'b1;
        end
        if (fin_go) begin
            r_status <= res_status;
            r_bucket <= bkt_ext[BUCKET_W-1:0];
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_status = r_status;
    assign o_bucket = r_bucket;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// channel   direction  handshake            fields
// request   in         i_push / o_full      i_opcode[1:0], i_key[30:0]
// result    out        o_empty / i_pop      o_status[1:0], o_bucket[3:0]
//
// Front: key mod BUCKETS by reciprocal multiply, in a quotient and a remainder state,
// then a push state that waits while the queue is full; o_full is high until the front
// is idle, so it takes no new request before the last is queued. Back: one probe per
// cycle from the slot memory read port, at most BUCKETS probes per request, then a
// finish state waiting for a free result register. Reset clears every slot; o_full is
// high. A held result stalls only the back; the front runs until its queue fills.
module linear_probe_hash_table import lph_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [OPC_W-1:0]    i_opcode,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [STATUS_W-1:0] o_status,
    output logic [BUCKET_W-1:0] o_bucket
);

    localparam int BW = $clog2(BUCKETS);
    localparam int CW = $bits(t_cmd);
    localparam int DW = BW + CW;

    logic          fe_busy;
    logic          fe_push;
    t_cmd          fe_cmd;
    logic [BW-1:0] fe_home;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic [DW-1:0] q_data;
    t_cmd          q_cmd;
    logic [BW-1:0] q_home;
    logic          clearing;
    logic          in_ok;

    assign o_full = fe_busy || clearing;
    assign in_ok  = i_push && !o_full;

    lph_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_ok),
        .i_opcode (i_opcode),
        .i_key    (i_key),
        .i_full   (q_full),
        .o_busy   (fe_busy),
        .o_push   (fe_push),
        .o_cmd    (fe_cmd),
        .o_home   (fe_home)
    );

    lph_fifo #(
        .DW    (DW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_home, fe_cmd}),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign q_cmd  = t_cmd'(q_data[CW-1:0]);
    assign q_home = q_data[DW-1 -: BW];

    lph_back #(
        .BUCKETS (BUCKETS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_cmd      (q_cmd),
        .i_home     (q_home),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_status   (o_status),
        .o_bucket   (o_bucket)
    );

    a_bucket_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != ST_DONE) |-> (o_bucket == '0))
        else $error("nonzero bucket on a failed request");

    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!q_empty && !clearing))
        else $error("back popped an empty queue or popped while clearing");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (o_empty && q_empty))
        else $error("activity during clearing pass");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import lph_pkg::*;

    localparam int BUCKETS        = BUCKETS_DEF;
    localparam int POOL           = 24;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 420;
    localparam logic [OPC_W-1:0] OPC_SPARE = 2'd3;

    class hash_scoreboard;
        t_mark               marks[BUCKETS];
        logic [KEY_W-1:0]    keys[BUCKETS];
        t_status             want_status[$];
        logic [BUCKET_W-1:0] want_bucket[$];
        int                  errors;
        int                  checked;
        int                  hist[4];

        function new();
            foreach (marks[i]) begin
                marks[i] = MARK_EMPTY;
                keys[i]  = '0;
            end
            errors  = 0;
            checked = 0;
            foreach (hist[i]) hist[i] = 0;
        endfunction

        function int pending();
            return want_status.size();
        endfunction

        function int next_bucket(int b);
            return (b + 1 >= BUCKETS) ? 0 : b + 1;
        endfunction

        // deleted slots are skipped, an empty slot ends the probe
        function bit lookup(input logic [KEY_W-1:0] key, output int where);
            int b;
            b     = int'(key % BUCKETS);
            where = 0;
            for (int n = 0; n < BUCKETS; n++) begin
                if (marks[b] == MARK_USED) begin
                    if (keys[b] == key) begin
                        where = b;
                        return 1'b1;
                    end
                end else if (marks[b] == MARK_EMPTY) begin
                    return 1'b0;
                end
                b = next_bucket(b);
            end
            return 1'b0;
        endfunction

        function void note_request(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] key);
            t_status             st;
            logic [BUCKET_W-1:0] bk;
            int                  at;
            int                  b;
            st = ST_NOTFOUND;
            bk = '0;
            case (op)
                OPC_INSERT: begin
                    if (lookup(key, at)) begin
                        st = ST_PRESENT;
                    end else begin
                        st = ST_FULL;
                        b  = int'(key % BUCKETS);
                        for (int n = 0; n < BUCKETS; n++) begin
                            if (marks[b] != MARK_USED) begin
                                keys[b]  = key;
                                marks[b] = MARK_USED;
                                st       = ST_DONE;
                                bk       = BUCKET_W'(b);
                                break;
                            end
                            b = next_bucket(b);
                        end
                    end
                end
                OPC_SEARCH: begin
                    if (lookup(key, at)) begin
                        st = ST_DONE;
                        bk = BUCKET_W'(at);
                    end
                end
                OPC_DELETE: begin
                    if (lookup(key, at)) begin
                        marks[at] = MARK_GONE;
                        st        = ST_DONE;
                        bk        = BUCKET_W'(at);
                    end
                end
                default: ;
            endcase
            want_status.push_back(st);
            want_bucket.push_back(bk);
        endfunction

        function void check_result(input logic [STATUS_W-1:0] status,
                                   input logic [BUCKET_W-1:0] bucket);
            t_status             ws;
            logic [BUCKET_W-1:0] wb;
            if (want_status.size() == 0) begin
                $error("result with no request waiting: status %0d bucket %0d", status, bucket);
                errors++;
                return;
            end
            ws = want_status.pop_front();
            wb = want_bucket.pop_front();
            checked++;
            hist[ws]++;
            if (status !== ws) begin
                $error("status: expected %0d, got %0d", ws, status);
                errors++;
            end
            if (bucket !== wb) begin
                $error("bucket: expected %0d, got %0d", wb, bucket);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n  = 1'b0;
    logic                i_push   = 1'b0;
    logic [OPC_W-1:0]    i_opcode = '0;
    logic [KEY_W-1:0]    i_key    = '0;
    logic                i_pop    = 1'b0;
    logic                o_full;
    logic                o_empty;
    logic [STATUS_W-1:0] o_status;
    logic [BUCKET_W-1:0] o_bucket;

    hash_scoreboard   sb = new();
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    int               quiet_cycles  = 0;
    int               sent          = 0;
    logic [KEY_W-1:0] key_pool[POOL];

    linear_probe_hash_table #(.BUCKETS(BUCKETS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_opcode (i_opcode),
        .i_key    (i_key),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_status (o_status),
        .o_bucket (o_bucket)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop        <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (i_pop && !o_empty) sb.check_result(o_status, o_bucket);
            if ((i_pop && !o_empty) || (i_push && !o_full)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            i_pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[linear_probe_hash_table] ERROR");
        $finish;
    end

    task automatic send_request(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push   <= 1'b1;
        i_opcode <= op;
        i_key    <= key;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sb.note_request(op, key);
        sent++;
    endtask

    // keys clustered around a few homes so probes collide and wrap
    task automatic refresh_pool();
        logic [31:0] r;
        int          base;
        base = $urandom_range(BUCKETS - 1);
        foreach (key_pool[i]) begin
            r = $urandom();
            if ($urandom_range(3) != 0) r[3:0] = 4'((base + $urandom_range(5)) % BUCKETS);
            key_pool[i] = r[KEY_W-1:0];
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int          sel;
        logic [31:0] r;
        sel = $urandom_range(99);
        r   = $urandom();
        if (sel < 75) return key_pool[$urandom_range(POOL - 1)];
        if (sel < 90) return r[KEY_W-1:0];
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return {{(KEY_W - 4){1'b1}}, 4'b0000};
            default: return KEY_W'(BUCKETS - 1);
        endcase
    endfunction

    function automatic logic [OPC_W-1:0] pick_op(int ins, int srch);
        int r;
        r = $urandom_range(99);
        if (r < ins) return OPC_INSERT;
        if (r < ins + srch) return OPC_SEARCH;
        if (r < 98) return OPC_DELETE;
        return OPC_SPARE;
    endfunction

    task automatic run_phase(int idle, int stall, int count);
        int done;
        int kind;
        int len;
        int ins;
        int srch;
        send_idle_pct = idle;
        stall_pct     = stall;
        done          = 0;
        while (done < count) begin
            kind = $urandom_range(9);
            len  = $urandom_range(15, 60);
            if ($urandom_range(2) == 0) refresh_pool();
            if (kind < 4) begin
                ins  = 70;
                srch = 20;
            end else if (kind < 8) begin
                ins  = 35;
                srch = 35;
            end else begin
                ins  = 5;
                srch = 30;
            end
            for (int i = 0; i < len; i++) send_request(pick_op(ins, srch), pick_key());
            done += len;
        end
    endtask

    initial begin
        refresh_pool();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, collisions, wrap at the top bucket, tombstone reuse
        send_request(OPC_SEARCH, '0);
        send_request(OPC_DELETE, '1);
        send_request(OPC_INSERT, '0);
        send_request(OPC_INSERT, '0);
        send_request(OPC_INSERT, 31'd16);
        send_request(OPC_INSERT, '1);
        send_request(OPC_INSERT, 31'd31);
        send_request(OPC_SEARCH, 31'd31);
        send_request(OPC_DELETE, 31'd16);
        send_request(OPC_SEARCH, 31'd31);
        send_request(OPC_INSERT, 31'd47);
        send_request(OPC_SPARE, '0);
        send_request(OPC_DELETE, '0);
        send_request(OPC_SEARCH, '0);
        send_request(OPC_INSERT, '0);
        send_request(OPC_DELETE, '0);
        send_request(OPC_DELETE, 31'd47);
        send_request(OPC_DELETE, 31'd31);
        send_request(OPC_DELETE, '1);
        send_request(OPC_SEARCH, '1);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(57, 0, PHASE_ITEMS);
        run_phase(0, 57, PHASE_ITEMS);
        run_phase(27, 27, PHASE_ITEMS);
        i_push <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d requests sent under four idle/stall mixes, %0d results checked",
                 sent, sb.checked);
        $display("outcomes: %0d done, %0d present, %0d not found, %0d table full",
                 sb.hist[ST_DONE], sb.hist[ST_PRESENT], sb.hist[ST_NOTFOUND], sb.hist[ST_FULL]);
        if (sb.errors == 0) begin
            $display("[linear_probe_hash_table] OK");
        end else begin
            $display("[linear_probe_hash_table] ERROR");
        end
        $finish;
    end

endmodule
